// ===== hdl/shf_pkg.sv =====
// Shared types and constants for the binary32/binary16 format converter.
// No dependencies; imported by every converter module.
`default_nettype none

package shf_pkg;

    // Operation codes carried with each transaction
    typedef enum logic [1:0] {
        OP_S2H   = 2'd0,
        OP_H2S   = 2'd1,
        OP_ROUND = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // binary16 encodings
    localparam logic [14:0] HALF_INF      = 15'h7c00;
    localparam logic [14:0] HALF_QNAN     = 15'h7e00;
    localparam logic [12:0] HALF_TIE      = 13'h1000;

    // binary32 encodings
    localparam logic [23:0] SGL_HIDDEN    = 24'h800000;
    localparam logic [30:0] SGL_INF       = 31'h7f800000;

    // Exponent bias difference and limits (single exponent field values)
    localparam logic [7:0]  EXP_ALL_ONES  = 8'hff;
    localparam logic [7:0]  EXP_OVF_MIN   = 8'd143;  // half exponent 31 and up
    localparam logic [7:0]  EXP_SUB_MAX   = 8'd112;  // half exponent 0 and below
    localparam logic [7:0]  EXP_TINY_MIN  = 8'd102;  // below this flushes to zero
    localparam logic [7:0]  EXP_SUB_SHIFT = 8'd126;  // shift = this - exponent
    localparam logic [7:0]  EXP_BIAS_DIFF = 8'd112;
    localparam logic [7:0]  EXP_SUB_NORM  = 8'd113;  // single exponent of half 2^-14

endpackage

`default_nettype wire

// ===== hdl/shf_s2h.sv =====
// Combinational binary32 to binary16 rounding (nearest, ties to even).
// Depends on shf_pkg.
`default_nettype none

module shf_s2h (
    input  wire logic [31:0] i_single,
    output logic      [15:0] o_half
);
    import shf_pkg::*;

    logic        sgn;
    logic [7:0]  exp_s;
    logic [22:0] man;
    logic [7:0]  sh_full;
    logic [4:0]  sh;
    logic [23:0] sig;
    logic [23:0] sub_q;
    logic [23:0] sub_r;
    logic [23:0] sub_mask;
    logic [23:0] sub_half;
    logic        sub_inc;
    logic [10:0] sub_res;
    logic [7:0]  he_full;
    logic [9:0]  nq;
    logic [12:0] nr;
    logic        n_inc;
    logic [14:0] norm_res;

    assign sgn   = i_single[31];
    assign exp_s = i_single[30:23];
    assign man   = i_single[22:0];

    // Subnormal path: shift significand right by 14..24 and round
    assign sh_full  = EXP_SUB_SHIFT - exp_s;
    assign sh       = sh_full[4:0];
    assign sig      = SGL_HIDDEN | {1'b0, man};
    assign sub_q    = sig >> sh;
    assign sub_mask = ~({24{1'b1}} << sh);
    assign sub_r    = sig & sub_mask;
    assign sub_half = 24'd1 << (sh - 5'd1);
    assign sub_inc  = (sub_r > sub_half) || ((sub_r == sub_half) && sub_q[0]);
    assign sub_res  = sub_q[10:0] + {10'd0, sub_inc};

    // Normal path: round mantissa; a carry walks into the exponent and may reach infinity
    assign he_full  = exp_s - EXP_BIAS_DIFF;
    assign nq       = man[22:13];
    assign nr       = man[12:0];
    assign n_inc    = (nr > HALF_TIE) || ((nr == HALF_TIE) && nq[0]);
    assign norm_res = {he_full[4:0], nq} + {14'd0, n_inc};

    // Select by exponent range
    always_comb begin
        if (exp_s == EXP_ALL_ONES) begin
            o_half = {sgn, (man == 23'd0) ? HALF_INF : HALF_QNAN};
        end else if (exp_s >= EXP_OVF_MIN) begin
            o_half = {sgn, HALF_INF};
        end else if (exp_s < EXP_TINY_MIN) begin
            o_half = {sgn, 15'd0};
        end else if (exp_s <= EXP_SUB_MAX) begin
            o_half = {sgn, 4'd0, sub_res};
        end else begin
            o_half = {sgn, norm_res};
        end
    end

endmodule

`default_nettype wire

// ===== hdl/shf_h2s.sv =====
// Combinational exact binary16 to binary32 widening with subnormal normalization.
// Depends on shf_pkg.
`default_nettype none

module shf_h2s (
    input  wire logic [15:0] i_half,
    output logic      [31:0] o_single
);
    import shf_pkg::*;

    logic        sgn;
    logic [4:0]  exp_h;
    logic [9:0]  man;
    logic [3:0]  lead;
    logic [3:0]  shamt;
    logic [10:0] norm_man;
    logic [7:0]  sub_exp;

    assign sgn   = i_half[15];
    assign exp_h = i_half[14:10];
    assign man   = i_half[9:0];

    // Find the leading one of a subnormal mantissa
    always_comb begin
        lead = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) begin
                lead = 4'(i);
            end
        end
    end

    assign shamt    = 4'd10 - lead;
    assign norm_man = {1'b0, man} << shamt;
    assign sub_exp  = EXP_SUB_NORM - {4'd0, shamt};

    // Select by exponent class
    always_comb begin
        if (exp_h == 5'd0) begin
            if (man == 10'd0) begin
                o_single = {sgn, 31'd0};
            end else begin
                o_single = {sgn, sub_exp, norm_man[9:0], 13'd0};
            end
        end else if (exp_h == 5'h1f) begin
            o_single = {sgn, SGL_INF | {8'd0, man, 13'd0}};
        end else begin
            o_single = {sgn, {3'd0, exp_h} + EXP_BIAS_DIFF, man, 13'd0};
        end
    end

endmodule

`default_nettype wire

// ===== hdl/single_half_float_converter.sv =====
// Top level of the binary32/binary16 format converter.
// Depends on shf_pkg, shf_s2h and shf_h2s.
// Each transaction passes through the input register and then the result register.
// o_valid is registered alongside the result and is high while o_result holds it.
// Throughput: one transaction per cycle; busy is never raised.
// Reset (synchronous, active low) clears the valid bits; results cannot be stalled.
`default_nettype none

module single_half_float_converter (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic [1:0]   i_operation,
    input  wire logic [31:0]  i_operand,
    output logic              o_valid,
    output logic      [31:0]  o_result
);
    import shf_pkg::*;

    logic        r_in_vld;
    logic [1:0]  r_op;
    logic [31:0] r_operand;
    logic        r_out_vld;
    logic [31:0] r_result;
    logic [31:0] n_result;
    logic [15:0] half;
    logic [15:0] h2s_in;
    logic [31:0] single;

    assign busy = 1'b0;

    // Capture each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= i_operation;
        r_operand <= i_operand;
    end

    shf_s2h u_s2h (
        .i_single (r_operand),
        .o_half   (half)
    );

    // Feed the widener from the operand or from the rounded half
    assign h2s_in = (t_op'(r_op) == OP_H2S) ? r_operand[15:0] : half;

    shf_h2s u_h2s (
        .i_half   (h2s_in),
        .o_single (single)
    );

    // Select the result by operation
    always_comb begin
        unique case (t_op'(r_op))
            OP_S2H:   n_result = {16'd0, half};
            OP_H2S:   n_result = single;
            OP_ROUND: n_result = single;
            default:  n_result = 32'd0;
        endcase
    end

    // Register the result and its strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== hdl/shf_checker.sv =====
// Port-level checker for the format converter and its bind to the top level.
// Depends on shf_pkg and single_half_float_converter.
`default_nettype none

module shf_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [1:0]  i_operation,
    input  wire logic        o_valid,
    input  wire logic [31:0] o_result
);
    import shf_pkg::*;

    // Never refuse a transaction
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy) else $error("busy raised");

    // Every accepted transaction is followed by a result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid) else $error("result missing");

    // No result without an accepted transaction
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2)) else $error("spurious result");

    // Single to half leaves the upper half of the result clear
    a_s2h_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == OP_S2H))
            |-> ##2 (!o_valid || (o_result[31:16] == 16'd0)))
        else $error("upper half not zero");

    // The unused code gives zero
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == OP_NONE))
            |-> ##2 (!o_valid || (o_result == 32'd0)))
        else $error("unused code gave nonzero result");

endmodule

bind single_half_float_converter shf_checker u_shf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_operation (i_operation),
    .o_valid     (o_valid),
    .o_result    (o_result)
);

`default_nettype wire
